// File: hdl/bba_pkg.sv
// Shared constants, types and codes of the buddy block allocator.
`timescale 1ns / 1ps
package bba_pkg;
    localparam int TOP_ORDER    = 10;
    localparam int UNIT_SHIFT   = 7;
    localparam int UNIT_BYTES   = 1 << UNIT_SHIFT;
    localparam int TOP_BLOCKS   = 32;
    localparam int HEADER_BYTES = 32;
    localparam int BLK_SHIFT    = $clog2(TOP_BLOCKS);
    localparam int UNIT_AW      = BLK_SHIFT + TOP_ORDER;
    localparam int TOTAL_UNITS  = 1 << UNIT_AW;
    localparam int ENTRY_W      = 6;

    // field widths
    localparam int SIZE_W  = 18;
    localparam int OFS_W   = 22;
    localparam int ORD_W   = 4;
    localparam int CNT_W   = 16;
    localparam int BYTES_W = 23;
    localparam int NEED_W  = SIZE_W + 1;

    localparam logic [NEED_W-1:0] TOP_BLOCK_BYTES = NEED_W'(UNIT_BYTES) << TOP_ORDER;

    typedef logic [1:0] status_t;
    localparam status_t STAT_OK       = 2'd0;
    localparam status_t STAT_BAD_SIZE = 2'd1;
    localparam status_t STAT_NO_MEM   = 2'd2;
    localparam status_t STAT_BAD_FREE = 2'd3;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // table entry: bit 5 block head, bit 4 free, bits 3..0 order
    typedef struct packed {
        logic             head;
        logic             free;
        logic [ORD_W-1:0] order;
    } entry_t;
endpackage

// File: hdl/bba_if.sv
// Valid/ready channels for allocator requests and responses.
`timescale 1ns / 1ps
interface bba_req_if;
    logic                       valid;
    logic                       ready;
    logic                       op;
    logic [bba_pkg::SIZE_W-1:0] request_size;
    logic [bba_pkg::OFS_W-1:0]  block_offset;
    modport source (output valid, op, request_size, block_offset, input ready);
    modport sink   (input valid, op, request_size, block_offset, output ready);
endinterface

interface bba_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [1:0]                  status;
    logic [bba_pkg::OFS_W-1:0]   granted_offset;
    logic [bba_pkg::ORD_W-1:0]   granted_order;
    logic [bba_pkg::CNT_W-1:0]   free_blocks;
    logic [bba_pkg::CNT_W-1:0]   used_blocks;
    logic [bba_pkg::BYTES_W-1:0] free_bytes;
    modport source (output valid, status, granted_offset, granted_order, free_blocks,
                    used_blocks, free_bytes, input ready);
    modport sink   (input valid, status, granted_offset, granted_order, free_blocks,
                    used_blocks, free_bytes, output ready);
endinterface

// File: hdl/buddy_block_allocator_unit.sv
// Top level: binary buddy allocator over a unit table held in RAM.
//
// req carries op (allocate or free), request_size and block_offset; rsp returns
// one transfer per request with status, granted block, and pool counters.
// After reset a clearing pass writes every table entry, one per cycle, over all
// 32768 entries (the table depth); req.ready stays low until it is done.
// Allocate: a read and a check for each block visited by the lowest-address
// scan (up to one block per table entry on a fully fragmented pool), then a
// split write per split order, a grant write and the output register load.
// Free: a read and a check of the block, a buddy read and check per merged
// order (at most ten merges), the merged head write and the output register
// load. A bad size or misaligned offset goes straight from idle to the load.
// Each table check is one read of the RAM read port, whose data is registered.
// req.ready rises again together with rsp.valid when the response is loaded.
// Only one request is in work at a time. A finished response sits in an
// output register; a new request is taken while it waits, and the block
// holds its next response until rsp.ready frees the register.
`timescale 1ns / 1ps
module buddy_block_allocator_unit (
    input  logic  clk,
    input  logic  rst_n,
    bba_req_if.sink   req,
    bba_rsp_if.source rsp
);
    import bba_pkg::*;

    typedef enum logic [9:0] {
        S_CLEAR = 10'b0000000001,
        S_IDLE  = 10'b0000000010,
        S_A_RD  = 10'b0000000100,
        S_A_CHK = 10'b0000001000,
        S_SPLIT = 10'b0000010000,
        S_F_RD  = 10'b0000100000,
        S_F_CHK = 10'b0001000000,
        S_M_RD  = 10'b0010000000,
        S_M_CHK = 10'b0100000000,
        S_DONE  = 10'b1000000000
    } state_t;

    state_t              state_reg, state_next;
    logic [UNIT_AW:0]    u_reg, u_next;
    logic [ORD_W-1:0]    k_reg, k_next;
    logic [ORD_W-1:0]    want_reg, want_next;
    logic [CNT_W-1:0]    free_cnt_reg, free_cnt_next;
    logic [CNT_W-1:0]    used_cnt_reg, used_cnt_next;
    logic [BYTES_W-1:0]  bytes_reg, bytes_next;
    status_t             res_stat_reg, res_stat_next;
    logic [OFS_W-1:0]    res_ofs_reg, res_ofs_next;
    logic [ORD_W-1:0]    res_ord_reg, res_ord_next;
    logic                out_valid_reg, out_valid_next;
    status_t             out_stat_reg, out_stat_next;
    logic [OFS_W-1:0]    out_ofs_reg, out_ofs_next;
    logic [ORD_W-1:0]    out_ord_reg, out_ord_next;
    logic [CNT_W-1:0]    out_free_reg, out_free_next;
    logic [CNT_W-1:0]    out_used_reg, out_used_next;
    logic [BYTES_W-1:0]  out_bytes_reg, out_bytes_next;

    logic                we;
    logic [UNIT_AW-1:0]  waddr, raddr;
    entry_t              wdata, rdata;
    logic [NEED_W-1:0]   need;
    logic [ORD_W-1:0]    want_c;
    logic [UNIT_AW-1:0]  u_lo, buddy;
    logic [UNIT_AW:0]    step_sum;
    logic [ORD_W-1:0]    k_dn;
    logic                out_free_slot;

    bba_ram #(.WIDTH(ENTRY_W), .DEPTH(TOTAL_UNITS)) u_table (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    // smallest order holding payload plus header
    always_comb
    begin
        need   = NEED_W'(req.request_size) + NEED_W'(HEADER_BYTES);
        want_c = ORD_W'(TOP_ORDER);
        for (int i = TOP_ORDER; i >= 0; i--)
        begin
            if ((NEED_W'(UNIT_BYTES) << i) >= need)
            begin
                want_c = ORD_W'(i);
            end
        end
    end

    assign u_lo          = u_reg[UNIT_AW-1:0];
    assign buddy         = u_lo ^ (UNIT_AW'(1) << k_reg);
    assign k_dn          = k_reg - ORD_W'(1);
    assign step_sum      = u_reg + ((UNIT_AW+1)'(1) << rdata.order);
    assign out_free_slot = !out_valid_reg || rsp.ready;
    assign req.ready     = (state_reg == S_IDLE);

    // read address per state
    always_comb
    begin
        case (state_reg)
            S_M_RD:  raddr = buddy;
            default: raddr = u_lo;
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        u_next         = u_reg;
        k_next         = k_reg;
        want_next      = want_reg;
        free_cnt_next  = free_cnt_reg;
        used_cnt_next  = used_cnt_reg;
        bytes_next     = bytes_reg;
        res_stat_next  = res_stat_reg;
        res_ofs_next   = res_ofs_reg;
        res_ord_next   = res_ord_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        out_stat_next  = out_stat_reg;
        out_ofs_next   = out_ofs_reg;
        out_ord_next   = out_ord_reg;
        out_free_next  = out_free_reg;
        out_used_next  = out_used_reg;
        out_bytes_next = out_bytes_reg;
        we             = 1'b0;
        waddr          = u_lo;
        wdata          = '0;
        case (state_reg)
            S_CLEAR:
            begin
                // each top block head starts free at top order, all else zero
                we = 1'b1;
                if (u_lo[TOP_ORDER-1:0] == '0)
                begin
                    wdata = '{head: 1'b1, free: 1'b1, order: ORD_W'(TOP_ORDER)};
                end
                u_next = u_reg + 1'b1;
                if (u_reg[UNIT_AW-1:0] == UNIT_AW'(TOTAL_UNITS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req.valid)
                begin
                    res_stat_next = STAT_OK;
                    res_ofs_next  = '0;
                    res_ord_next  = '0;
                    if (req.op == OP_ALLOC)
                    begin
                        want_next = want_c;
                        u_next    = '0;
                        if (req.request_size == '0 || need > TOP_BLOCK_BYTES)
                        begin
                            res_stat_next = STAT_BAD_SIZE;
                            state_next    = S_DONE;
                        end
                        else
                        begin
                            state_next = S_A_RD;
                        end
                    end
                    else
                    begin
                        u_next = {1'b0, req.block_offset[OFS_W-1:UNIT_SHIFT]};
                        if (req.block_offset[UNIT_SHIFT-1:0] != '0)
                        begin
                            res_stat_next = STAT_BAD_FREE;
                            state_next    = S_DONE;
                        end
                        else
                        begin
                            state_next = S_F_RD;
                        end
                    end
                end
            end
            S_A_RD:
            begin
                state_next = S_A_CHK;
            end
            S_A_CHK:
            begin
                // scan: take first free head of order at least want
                if (rdata.head && rdata.free && rdata.order >= want_reg &&
                    rdata.order <= ORD_W'(TOP_ORDER))
                begin
                    k_next     = rdata.order;
                    state_next = S_SPLIT;
                end
                else
                begin
                    if (!rdata.head || rdata.order > ORD_W'(TOP_ORDER))
                    begin
                        u_next = u_reg + 1'b1;
                    end
                    else
                    begin
                        u_next = step_sum;
                    end
                    if (u_next[UNIT_AW])
                    begin
                        res_stat_next = STAT_NO_MEM;
                        state_next    = S_DONE;
                    end
                    else
                    begin
                        state_next = S_A_RD;
                    end
                end
            end
            S_SPLIT:
            begin
                we = 1'b1;
                if (k_reg > want_reg)
                begin
                    // release the upper half
                    waddr         = u_lo + (UNIT_AW'(1) << k_dn);
                    wdata         = '{head: 1'b1, free: 1'b1, order: k_dn};
                    k_next        = k_dn;
                    free_cnt_next = free_cnt_reg + 1'b1;
                end
                else
                begin
                    wdata         = '{head: 1'b1, free: 1'b0, order: want_reg};
                    free_cnt_next = free_cnt_reg - 1'b1;
                    used_cnt_next = used_cnt_reg + 1'b1;
                    bytes_next    = bytes_reg - (BYTES_W'(UNIT_BYTES) << want_reg);
                    res_ofs_next  = {u_lo, UNIT_SHIFT'(0)};
                    res_ord_next  = want_reg;
                    state_next    = S_DONE;
                end
            end
            S_F_RD:
            begin
                state_next = S_F_CHK;
            end
            S_F_CHK:
            begin
                if (!rdata.head || rdata.free || rdata.order > ORD_W'(TOP_ORDER))
                begin
                    res_stat_next = STAT_BAD_FREE;
                    state_next    = S_DONE;
                end
                else
                begin
                    k_next        = rdata.order;
                    free_cnt_next = free_cnt_reg + 1'b1;
                    used_cnt_next = used_cnt_reg - 1'b1;
                    bytes_next    = bytes_reg + (BYTES_W'(UNIT_BYTES) << rdata.order);
                    state_next    = S_M_RD;
                end
            end
            S_M_RD:
            begin
                // at top order the merge stops; otherwise read the buddy
                if (k_reg == ORD_W'(TOP_ORDER))
                begin
                    we           = 1'b1;
                    wdata        = '{head: 1'b1, free: 1'b1, order: k_reg};
                    res_ord_next = k_reg;
                    state_next   = S_DONE;
                end
                else
                begin
                    state_next = S_M_CHK;
                end
            end
            S_M_CHK:
            begin
                we = 1'b1;
                if (rdata == entry_t'{head: 1'b1, free: 1'b1, order: k_reg})
                begin
                    // clear the upper of the pair, keep the lower as head
                    waddr         = (buddy > u_lo) ? buddy : u_lo;
                    wdata         = '0;
                    u_next        = {1'b0, ((buddy < u_lo) ? buddy : u_lo)};
                    k_next        = k_reg + 1'b1;
                    free_cnt_next = free_cnt_reg - 1'b1;
                    state_next    = S_M_RD;
                end
                else
                begin
                    wdata        = '{head: 1'b1, free: 1'b1, order: k_reg};
                    res_ord_next = k_reg;
                    state_next   = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free_slot)
                begin
                    out_valid_next = 1'b1;
                    out_stat_next  = res_stat_reg;
                    out_ofs_next   = res_ofs_reg;
                    out_ord_next   = res_ord_reg;
                    out_free_next  = free_cnt_reg;
                    out_used_next  = used_cnt_reg;
                    out_bytes_next = bytes_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            u_reg         <= '0;
            free_cnt_reg  <= CNT_W'(TOP_BLOCKS);
            used_cnt_reg  <= '0;
            bytes_reg     <= BYTES_W'(TOP_BLOCKS) << (TOP_ORDER + UNIT_SHIFT);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            u_reg         <= u_next;
            free_cnt_reg  <= free_cnt_next;
            used_cnt_reg  <= used_cnt_next;
            bytes_reg     <= bytes_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        k_reg         <= k_next;
        want_reg      <= want_next;
        res_stat_reg  <= res_stat_next;
        res_ofs_reg   <= res_ofs_next;
        res_ord_reg   <= res_ord_next;
        out_stat_reg  <= out_stat_next;
        out_ofs_reg   <= out_ofs_next;
        out_ord_reg   <= out_ord_next;
        out_free_reg  <= out_free_next;
        out_used_reg  <= out_used_next;
        out_bytes_reg <= out_bytes_next;
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.status         = out_stat_reg;
    assign rsp.granted_offset = out_ofs_reg;
    assign rsp.granted_order  = out_ord_reg;
    assign rsp.free_blocks    = out_free_reg;
    assign rsp.used_blocks    = out_used_reg;
    assign rsp.free_bytes     = out_bytes_reg;

    // checks
    a_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("sequencer state not one-hot");
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.status != STAT_OK) |-> (rsp.granted_offset == '0))
        else $error("failed response carries an offset");
    a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE || state_reg == S_DONE) |-> !we)
        else $error("table write outside a work state");
    a_split_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SPLIT) |-> (k_reg >= want_reg && k_reg <= ORD_W'(TOP_ORDER)))
        else $error("split order out of range");
endmodule

// File: hdl/bba_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module bba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
